/* rtl/sac_pkg.sv */
// shared constants, codes and types of the shape area calculator
package sac_pkg;

  // field widths
  localparam int LEN_W  = 24;   // signed q16.8 length
  localparam int AREA_W = 40;   // unsigned q32.8 area
  localparam int CMD_W  = 2;

  // first multiplier: 25 x 24 bits
  localparam int SUM_W = LEN_W + 2;   // signed sum of three lengths
  localparam int MX_W  = LEN_W + 1;
  localparam int MY_W  = LEN_W;
  localparam int X_W   = MX_W + MY_W; // 49
  localparam int Y_W   = 2 * MY_W;    // 48

  // second multiplier, split into four partial products
  localparam int LO_W  = 25;
  localparam int XH_W  = X_W - LO_W;  // 24
  localparam int YH_W  = Y_W - LO_W;  // 23
  localparam int MID_W = X_W + 1;     // 50
  localparam int P_W   = X_W + Y_W;   // 97

  // square root
  localparam int ROOT_W     = 51;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SQRT_SHIFT = 10;     // isqrt(16 * area^2) -> q.8 area
  localparam int CR_SHIFT   = 24;     // circle and rectangle scaling

  localparam logic [17:0] PI_Q16     = 18'd205887;
  localparam logic [16:0] RECT_SCALE = 17'h10000;

  typedef enum logic [CMD_W-1:0] {
    CMD_CIRCLE = 2'd0,
    CMD_RECT   = 2'd1,
    CMD_TRI    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic is_tri;
    logic is_circ;
  } flags_t;

  // sideband that rides along the square root pipeline
  typedef struct packed {
    logic              ok;
    logic              is_tri;
    logic [AREA_W-1:0] area;
  } side_t;

endpackage

/* rtl/shape_area_calculator_core.sv */
// top level of the shape area calculator: checks, multipliers and output stage
//
// One item in, one result out, one item per clock. An item is taken at any
// rising edge with start high and busy low; busy is high only while rst_n is
// low and in the first cycle after it. Every result appears on out_area and
// out_valid_res, marked by out_strobe for one cycle, in the order in which
// the items were taken. The receiver cannot hold results off. The path is
// five arithmetic stages (checks, first multiply, split second multiply,
// partial sum, final sum) that feed a 51-stage restoring root that resolves
// one root bit per stage, followed by one output register. Circle and
// rectangle items pass through the same stages so that order is kept.
// Invalid dimensions and the unused shape code give area 0 with
// out_valid_res low.
module shape_area_calculator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [sac_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [sac_pkg::LEN_W-1:0]   in_len_a,
  input  logic signed [sac_pkg::LEN_W-1:0]   in_len_b,
  input  logic signed [sac_pkg::LEN_W-1:0]   in_len_c,
  output logic                               out_strobe,
  output logic [sac_pkg::AREA_W-1:0]         out_area,
  output logic                               out_valid_res
);

  localparam int LenW  = sac_pkg::LEN_W;
  localparam int SumW  = sac_pkg::SUM_W;
  localparam int MxW   = sac_pkg::MX_W;
  localparam int MyW   = sac_pkg::MY_W;
  localparam int XW    = sac_pkg::X_W;
  localparam int YW    = sac_pkg::Y_W;
  localparam int LoW   = sac_pkg::LO_W;
  localparam int XhW   = sac_pkg::XH_W;
  localparam int YhW   = sac_pkg::YH_W;
  localparam int MidW  = sac_pkg::MID_W;
  localparam int PW    = sac_pkg::P_W;
  localparam int RadW  = sac_pkg::RAD_W;
  localparam int RootW = sac_pkg::ROOT_W;
  localparam int AreaW = sac_pkg::AREA_W;
  localparam int Sh    = sac_pkg::SQRT_SHIFT;
  localparam int CrSh  = sac_pkg::CR_SHIFT;

  // ---------------------------------------------------------------------------
  // handshake: the pipeline never stalls, so only reset holds items off
  // ---------------------------------------------------------------------------
  logic busy_r;
  logic in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r | ~rst_n;
  assign in_acc = start & ~busy;

  // ---------------------------------------------------------------------------
  // stage 1: dimension checks and operand selection
  // ---------------------------------------------------------------------------
  logic signed [SumW-1:0] sum_p, sum_q, sum_r, sum_t;
  logic                   a_pos, b_pos, tri_ok;
  sac_pkg::flags_t        flags1_nxt;
  logic [MxW-1:0]         x1_nxt;
  logic [MyW-1:0]         y1_nxt, x2_nxt, y2_nxt;

  // perimeter and the three Heron differences, each side taken once negated
  assign sum_p = SumW'(in_len_a) + SumW'(in_len_b) + SumW'(in_len_c);
  assign sum_q = SumW'(in_len_b) + SumW'(in_len_c) - SumW'(in_len_a);
  assign sum_r = SumW'(in_len_a) + SumW'(in_len_c) - SumW'(in_len_b);
  assign sum_t = SumW'(in_len_a) + SumW'(in_len_b) - SumW'(in_len_c);

  assign a_pos  = ~in_len_a[LenW-1] & (in_len_a != '0);
  assign b_pos  = ~in_len_b[LenW-1] & (in_len_b != '0);
  // any side at or above the sum of the others makes a difference non-positive
  assign tri_ok = (sum_q > 0) && (sum_r > 0) && (sum_t > 0);

  always_comb begin
    flags1_nxt = '0;
    x1_nxt     = '0;
    y1_nxt     = '0;
    x2_nxt     = '0;
    y2_nxt     = '0;
    unique case (sac_pkg::cmd_t'(in_cmd))
      sac_pkg::CMD_CIRCLE: begin
        // r * r, scaled by pi later
        flags1_nxt.ok      = a_pos;
        flags1_nxt.is_circ = 1'b1;
        x1_nxt = {{(MxW-LenW+1){1'b0}}, in_len_a[LenW-2:0]};
        y1_nxt = {{(MyW-LenW+1){1'b0}}, in_len_a[LenW-2:0]};
      end
      sac_pkg::CMD_RECT: begin
        flags1_nxt.ok = a_pos & b_pos;
        x1_nxt = {{(MxW-LenW+1){1'b0}}, in_len_a[LenW-2:0]};
        y1_nxt = {{(MyW-LenW+1){1'b0}}, in_len_b[LenW-2:0]};
      end
      sac_pkg::CMD_TRI: begin
        flags1_nxt.ok     = tri_ok;
        flags1_nxt.is_tri = 1'b1;
        x1_nxt = sum_p[MxW-1:0];
        y1_nxt = sum_q[MyW-1:0];
        x2_nxt = sum_r[MyW-1:0];
        y2_nxt = sum_t[MyW-1:0];
      end
      sac_pkg::CMD_NONE: begin
        flags1_nxt.ok = 1'b0;
      end
      default: begin
        flags1_nxt = '0;
      end
    endcase
  end

  logic            vld1_r;
  sac_pkg::flags_t flags1_r;
  logic [MxW-1:0]  x1_r;
  logic [MyW-1:0]  y1_r, x2_r, y2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    flags1_r <= flags1_nxt;
    x1_r     <= x1_nxt;
    y1_r     <= y1_nxt;
    x2_r     <= x2_nxt;
    y2_r     <= y2_nxt;
  end

  // ---------------------------------------------------------------------------
  // stage 2: first products (p*q or the circle/rectangle product, and r*t)
  // ---------------------------------------------------------------------------
  logic            vld2_r;
  sac_pkg::flags_t flags2_r;
  logic [XW-1:0]   m1_nxt, m1_r;
  logic [YW-1:0]   m2_nxt, m2_r;

  assign m1_nxt = XW'(x1_r) * XW'(y1_r);
  assign m2_nxt = YW'(x2_r) * YW'(y2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    flags2_r <= flags1_r;
    m1_r     <= m1_nxt;
    m2_r     <= m2_nxt;
  end

  // ---------------------------------------------------------------------------
  // stage 3: second multiply as four partial products
  // circle scales by pi, rectangle by 2^16, so both end up shifted by 24
  // ---------------------------------------------------------------------------
  logic [YW-1:0]          y_sel;
  logic [XhW+YhW-1:0]     hh_nxt;
  logic [XhW+LoW-1:0]     hl_nxt;
  logic [LoW+YhW-1:0]     lh_nxt;
  logic [2*LoW-1:0]       ll_nxt;

  always_comb begin
    if (flags2_r.is_tri) begin
      y_sel = m2_r;
    end else if (flags2_r.is_circ) begin
      y_sel = {{(YW-$bits(sac_pkg::PI_Q16)){1'b0}}, sac_pkg::PI_Q16};
    end else begin
      y_sel = {{(YW-$bits(sac_pkg::RECT_SCALE)){1'b0}}, sac_pkg::RECT_SCALE};
    end
  end

  assign hh_nxt = (XhW+YhW)'(m1_r[XW-1:LoW]) * (XhW+YhW)'(y_sel[YW-1:LoW]);
  assign hl_nxt = (XhW+LoW)'(m1_r[XW-1:LoW]) * (XhW+LoW)'(y_sel[LoW-1:0]);
  assign lh_nxt = (LoW+YhW)'(m1_r[LoW-1:0])  * (LoW+YhW)'(y_sel[YW-1:LoW]);
  assign ll_nxt = (2*LoW)'(m1_r[LoW-1:0])    * (2*LoW)'(y_sel[LoW-1:0]);

  logic                vld3_r;
  sac_pkg::flags_t     flags3_r;
  logic [XhW+YhW-1:0]  hh3_r;
  logic [XhW+LoW-1:0]  hl3_r;
  logic [LoW+YhW-1:0]  lh3_r;
  logic [2*LoW-1:0]    ll3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    flags3_r <= flags2_r;
    hh3_r    <= hh_nxt;
    hl3_r    <= hl_nxt;
    lh3_r    <= lh_nxt;
    ll3_r    <= ll_nxt;
  end

  // ---------------------------------------------------------------------------
  // stage 4: add the two cross terms
  // ---------------------------------------------------------------------------
  logic                vld4_r;
  sac_pkg::flags_t     flags4_r;
  logic [MidW-1:0]     mid_nxt, mid4_r;
  logic [XhW+YhW-1:0]  hh4_r;
  logic [2*LoW-1:0]    ll4_r;

  assign mid_nxt = MidW'(hl3_r) + MidW'(lh3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else begin
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    flags4_r <= flags3_r;
    mid4_r   <= mid_nxt;
    hh4_r    <= hh3_r;
    ll4_r    <= ll3_r;
  end

  // ---------------------------------------------------------------------------
  // stage 5: full product, circle and rectangle area taken here
  // ---------------------------------------------------------------------------
  logic [PW-1:0]   prod_nxt;
  sac_pkg::side_t  side5_nxt, side5_r;
  logic            vld5_r;
  logic [PW-1:0]   prod5_r;

  assign prod_nxt = (PW'(hh4_r) << (2*LoW)) + (PW'(mid4_r) << LoW) + PW'(ll4_r);

  always_comb begin
    side5_nxt.ok     = flags4_r.ok;
    side5_nxt.is_tri = flags4_r.is_tri;
    side5_nxt.area   = prod_nxt[CrSh+AreaW-1:CrSh];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else begin
      vld5_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    side5_r <= side5_nxt;
    prod5_r <= prod_nxt;
  end

  // ---------------------------------------------------------------------------
  // square root of 16 * area^2 for triangles
  // ---------------------------------------------------------------------------
  logic               sq_vld;
  logic [RootW-1:0]   sq_root;
  sac_pkg::side_t     sq_side;

  sac_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld5_r),
    .in_rad   ({{(RadW-PW){1'b0}}, prod5_r}),
    .in_side  (side5_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // ---------------------------------------------------------------------------
  // output register: area forced to zero for invalid items
  // ---------------------------------------------------------------------------
  logic              out_strobe_r;
  logic              out_valid_res_r;
  logic [AreaW-1:0]  out_area_nxt, out_area_r;

  always_comb begin
    if (!sq_side.ok) begin
      out_area_nxt = '0;
    end else if (sq_side.is_tri) begin
      out_area_nxt = sq_root[Sh+AreaW-1:Sh];
    end else begin
      out_area_nxt = sq_side.area;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r    <= 1'b0;
      out_valid_res_r <= 1'b0;
    end else begin
      out_strobe_r    <= sq_vld;
      out_valid_res_r <= sq_vld & sq_side.ok;
    end
  end

  always_ff @(posedge clk) begin
    out_area_r <= out_area_nxt;
  end

  assign out_strobe    = out_strobe_r;
  assign out_valid_res = out_valid_res_r;
  assign out_area      = out_area_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_valid_res |-> out_area == '0)
    else $error("invalid item with non-zero area");

  a_valid_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_res |-> out_strobe)
    else $error("valid flag without result strobe");

  a_no_busy: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

  a_tri_sides: assert property (@(posedge clk) disable iff (!rst_n)
    vld1_r && flags1_r.ok && flags1_r.is_tri |-> x2_r != '0 && y2_r != '0)
    else $error("accepted triangle with a degenerate side difference");

endmodule

/* rtl/sac_sqrt_pipe.sv */
// pipelined restoring square root, one root bit per stage
module sac_sqrt_pipe (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  logic [sac_pkg::RAD_W-1:0]    in_rad,
  input  sac_pkg::side_t               in_side,
  output logic                         out_vld,
  output logic [sac_pkg::ROOT_W-1:0]   out_root,
  output sac_pkg::side_t               out_side
);

  localparam int RootW = sac_pkg::ROOT_W;
  localparam int RadW  = sac_pkg::RAD_W;
  localparam int RemW  = sac_pkg::REM_W;

  logic                 vld_r  [RootW];
  logic [RadW-1:0]      rad_r  [RootW];
  logic [RemW-1:0]      rem_r  [RootW];
  logic [RootW-1:0]     root_r [RootW];
  sac_pkg::side_t       side_r [RootW];

  genvar g;
  generate
    for (g = 0; g < RootW; g++) begin : g_stage
      logic             src_vld;
      logic [RadW-1:0]  src_rad;
      logic [RemW-1:0]  src_rem;
      logic [RootW-1:0] src_root;
      sac_pkg::side_t   src_side;
      logic [RemW-1:0]  rem_sh;
      logic [RemW-1:0]  trial;
      logic             take;

      if (g == 0) begin : g_first
        assign src_vld  = in_vld;
        assign src_rad  = in_rad;
        assign src_rem  = '0;
        assign src_root = '0;
        assign src_side = in_side;
      end else begin : g_next
        assign src_vld  = vld_r[g-1];
        assign src_rad  = rad_r[g-1];
        assign src_rem  = rem_r[g-1];
        assign src_root = root_r[g-1];
        assign src_side = side_r[g-1];
      end

      // bring down the next two radicand bits, try root*4 + 1
      assign rem_sh = {src_rem[RemW-3:0], src_rad[RadW-1:RadW-2]};
      assign trial  = {{(RemW-RootW-2){1'b0}}, src_root, 2'b01};
      assign take   = (rem_sh >= trial);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[g] <= 1'b0;
        end else begin
          vld_r[g] <= src_vld;
        end
      end

      always_ff @(posedge clk) begin
        rad_r[g]  <= {src_rad[RadW-3:0], 2'b00};
        rem_r[g]  <= take ? (rem_sh - trial) : rem_sh;
        root_r[g] <= {src_root[RootW-2:0], take};
        side_r[g] <= src_side;
      end
    end
  endgenerate

  assign out_vld  = vld_r[RootW-1];
  assign out_root = root_r[RootW-1];
  assign out_side = side_r[RootW-1];

  // remainder of a floor root never exceeds twice the root
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[RootW-1] |->
      rem_r[RootW-1] <= {{(RemW-RootW-1){1'b0}}, root_r[RootW-1], 1'b0})
    else $error("square root remainder out of range");

endmodule

/* tb/sv/testbench.sv */
// testbench for the shape area calculator: directed table, random items, area predictor
`timescale 1ns / 100ps

module testbench;

  localparam logic signed [sac_pkg::LEN_W-1:0] LEN_MAX = 24'sh7FFFFF;
  localparam logic signed [sac_pkg::LEN_W-1:0] LEN_MIN = 24'sh800000;
  localparam int NUM_DIRECTED = 24;
  localparam int NUM_RANDOM   = 700;
  localparam int DRAIN_CYCLES = 64;   // longer than the pipeline of the block

  // one result of the block
  typedef struct packed {
    logic [sac_pkg::AREA_W-1:0] area;
    logic                       valid_res;
  } area_res_t;

  // one row of the directed table; fixed_exp marks rows whose result is typed in
  typedef struct packed {
    sac_pkg::cmd_t                     cmd;
    logic signed [sac_pkg::LEN_W-1:0]  len_a;
    logic signed [sac_pkg::LEN_W-1:0]  len_b;
    logic signed [sac_pkg::LEN_W-1:0]  len_c;
    logic                              fixed_exp;
    area_res_t                         res;
  } stim_row_t;

  logic                              clk;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic [sac_pkg::CMD_W-1:0]         in_cmd;
  logic signed [sac_pkg::LEN_W-1:0]  in_len_a;
  logic signed [sac_pkg::LEN_W-1:0]  in_len_b;
  logic signed [sac_pkg::LEN_W-1:0]  in_len_c;
  logic                              out_strobe;
  logic [sac_pkg::AREA_W-1:0]        out_area;
  logic                              out_valid_res;

  area_res_t pending_areas[$];   // expected results, oldest first
  int        error_count = 0;

  // directed rows: every shape, the field extremes, each rejection rule
  stim_row_t directed_rows [0:NUM_DIRECTED-1] = '{
    // circle: zero, negative and most negative radius are rejected
    '{sac_pkg::CMD_CIRCLE, 24'sd0,   24'sd0,   24'sd0,   1'b1, '{40'd0, 1'b0}},
    '{sac_pkg::CMD_CIRCLE, -24'sd1,  24'sd0,   24'sd0,   1'b1, '{40'd0, 1'b0}},
    '{sac_pkg::CMD_CIRCLE, LEN_MIN,  LEN_MAX,  LEN_MAX,  1'b1, '{40'd0, 1'b0}},
    // smallest radius: valid, area truncates to zero
    '{sac_pkg::CMD_CIRCLE, 24'sd1,   24'sd0,   24'sd0,   1'b1, '{40'd0, 1'b1}},
    '{sac_pkg::CMD_CIRCLE, LEN_MAX,  LEN_MIN,  LEN_MIN,  1'b0, '{40'd0, 1'b0}},
    '{sac_pkg::CMD_CIRCLE, 24'sd256, LEN_MAX,  -24'sd1,  1'b0, '{40'd0, 1'b0}},
    // rectangle: each side rejected on its own
    '{sac_pkg::CMD_RECT,   24'sd0,   24'sd256, 24'sd0,   1'b1, '{40'd0, 1'b0}},
    '{sac_pkg::CMD_RECT,   24'sd256, -24'sd1,  24'sd0,   1'b1, '{40'd0, 1'b0}},
    '{sac_pkg::CMD_RECT,   LEN_MIN,  LEN_MIN,  LEN_MAX,  1'b1, '{40'd0, 1'b0}},
    // unit square and the smallest sides
    '{sac_pkg::CMD_RECT,   24'sd256, 24'sd256, 24'sd0,   1'b1, '{40'd256, 1'b1}},
    '{sac_pkg::CMD_RECT,   24'sd1,   24'sd1,   LEN_MIN,  1'b1, '{40'd0, 1'b1}},
    '{sac_pkg::CMD_RECT,   LEN_MAX,  LEN_MAX,  LEN_MAX,  1'b0, '{40'd0, 1'b0}},
    // triangle: 3-4-5 gives area 6.0
    '{sac_pkg::CMD_TRI,    24'sd768, 24'sd1024, 24'sd1280, 1'b1, '{40'd1536, 1'b1}},
    // degenerate, zero side, negative side, all most negative
    '{sac_pkg::CMD_TRI,    24'sd256, 24'sd256, 24'sd512, 1'b1, '{40'd0, 1'b0}},
    '{sac_pkg::CMD_TRI,    24'sd0,   24'sd256, 24'sd256, 1'b1, '{40'd0, 1'b0}},
    '{sac_pkg::CMD_TRI,    -24'sd256, 24'sd512, 24'sd512, 1'b1, '{40'd0, 1'b0}},
    '{sac_pkg::CMD_TRI,    LEN_MIN,  LEN_MIN,  LEN_MIN,  1'b1, '{40'd0, 1'b0}},
    // largest and slimmest triangles
    '{sac_pkg::CMD_TRI,    LEN_MAX,  LEN_MAX,  LEN_MAX,  1'b0, '{40'd0, 1'b0}},
    '{sac_pkg::CMD_TRI,    LEN_MAX,  LEN_MAX,  24'sd1,   1'b0, '{40'd0, 1'b0}},
    '{sac_pkg::CMD_TRI,    24'sd1,   24'sd1,   24'sd1,   1'b1, '{40'd0, 1'b1}},
    '{sac_pkg::CMD_TRI,    LEN_MAX,  24'sd1,   LEN_MAX,  1'b0, '{40'd0, 1'b0}},
    '{sac_pkg::CMD_TRI,    24'sd512, 24'sd256, 24'sd257, 1'b0, '{40'd0, 1'b0}},
    // unused shape code never gives a valid result
    '{sac_pkg::CMD_NONE,   24'sd256, 24'sd256, 24'sd256, 1'b1, '{40'd0, 1'b0}},
    '{sac_pkg::CMD_NONE,   LEN_MIN,  LEN_MAX,  -24'sd1,  1'b1, '{40'd0, 1'b0}}
  };

  shape_area_calculator_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_len_a      (in_len_a),
    .in_len_b      (in_len_b),
    .in_len_c      (in_len_c),
    .out_strobe    (out_strobe),
    .out_area      (out_area),
    .out_valid_res (out_valid_res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // floor square root of a product below 2^100, one root bit per step
  function automatic logic [sac_pkg::ROOT_W-1:0] floor_sqrt(input logic [127:0] radicand);
    logic [sac_pkg::ROOT_W-1:0] root;
    logic [sac_pkg::ROOT_W-1:0] trial;
    logic [127:0]               trial_wide;
    root = '0;
    for (int idx = sac_pkg::ROOT_W - 1; idx >= 0; idx--) begin
      trial = root | (sac_pkg::ROOT_W'(1) << idx);
      trial_wide = 128'(trial);
      if (trial_wide * trial_wide <= radicand) root = trial;
    end
    return root;
  endfunction

  // expected area and validity of one item
  function automatic area_res_t predict_shape_area(
      input sac_pkg::cmd_t cmd,
      input logic signed [sac_pkg::LEN_W-1:0] len_a,
      input logic signed [sac_pkg::LEN_W-1:0] len_b,
      input logic signed [sac_pkg::LEN_W-1:0] len_c);
    area_res_t    res;
    longint       a, b, c;
    logic [127:0] wide, pq, rt;
    a = len_a;
    b = len_b;
    c = len_c;
    res = '0;
    case (cmd)
      sac_pkg::CMD_CIRCLE: begin
        if (a > 0) begin
          wide = 128'(a);
          wide = (wide * wide * 128'(sac_pkg::PI_Q16)) >> sac_pkg::CR_SHIFT;
          res = '{wide[sac_pkg::AREA_W-1:0], 1'b1};
        end
      end
      sac_pkg::CMD_RECT: begin
        if (a > 0 && b > 0) begin
          wide = (128'(a) * 128'(b)) >> 8;
          res = '{wide[sac_pkg::AREA_W-1:0], 1'b1};
        end
      end
      sac_pkg::CMD_TRI: begin
        // strict triangle inequality also rejects zero and negative sides
        if (!(a >= b + c || b >= a + c || c >= a + b)) begin
          pq = 128'((a + b + c) * (b + c - a));
          rt = 128'((a + c - b) * (a + b - c));
          wide = 128'(floor_sqrt(pq * rt)) >> sac_pkg::SQRT_SHIFT;
          res = '{wide[sac_pkg::AREA_W-1:0], 1'b1};
        end
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  // present one item and hold it until taken; the expectation is queued on acceptance
  task automatic send_item(input sac_pkg::cmd_t cmd,
                           input logic signed [sac_pkg::LEN_W-1:0] len_a,
                           input logic signed [sac_pkg::LEN_W-1:0] len_b,
                           input logic signed [sac_pkg::LEN_W-1:0] len_c,
                           input logic use_fixed,
                           input area_res_t fixed_res);
    start    <= 1'b1;
    in_cmd   <= cmd;
    in_len_a <= len_a;
    in_len_b <= len_b;
    in_len_c <= len_c;
    do @(posedge clk); while (busy !== 1'b0);
    if (use_fixed) pending_areas.push_back(fixed_res);
    else pending_areas.push_back(predict_shape_area(cmd, len_a, len_b, len_c));
  endtask

  // idle the input for a random stretch unless bursting: mostly short, now and then long
  task automatic input_gap(input logic bursting);
    int cycles;
    if (bursting) cycles = 0;
    else if ($urandom_range(9, 0) == 0) cycles = $urandom_range(40, 10);
    else if ($urandom_range(1, 0) == 0) cycles = 0;
    else cycles = $urandom_range(3, 1);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // positive length: small or medium in half the draws, across the full range in the rest
  function automatic logic signed [sac_pkg::LEN_W-1:0] pick_side();
    case ($urandom_range(3, 0))
      0:       return sac_pkg::LEN_W'($urandom_range(1023, 1));
      1:       return sac_pkg::LEN_W'($urandom_range(65535, 1));
      default: return sac_pkg::LEN_W'($urandom_range(32'h7FFFFF, 1));
    endcase
  endfunction

  // result checker: every strobe must match the oldest expectation
  always @(posedge clk) begin
    area_res_t want;
    if (rst_n && out_strobe) begin
      if (pending_areas.size() == 0) begin
        $display("%0t: unexpected result area=%0d valid_res=%0b",
                 $time, out_area, out_valid_res);
        error_count++;
      end else begin
        want = pending_areas.pop_front();
        if (out_area !== want.area) begin
          $display("%0t: area mismatch, expected %0d, got %0d", $time, want.area, out_area);
          error_count++;
        end
        if (out_valid_res !== want.valid_res) begin
          $display("%0t: valid_res mismatch, expected %0b, got %0b",
                   $time, want.valid_res, out_valid_res);
          error_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    sac_pkg::cmd_t                    cmd;
    logic signed [sac_pkg::LEN_W-1:0] s0, s1, s2, tmp;
    int                               lo, hi;
    logic                             bursting;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_cmd   = '0;
    in_len_a = '0;
    in_len_b = '0;
    in_len_c = '0;
    bursting = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cmd, directed_rows[i].len_a, directed_rows[i].len_b,
                directed_rows[i].len_c, directed_rows[i].fixed_exp, directed_rows[i].res);
      input_gap(i < 8);
    end

    // random items, mostly well-formed shapes with some raw noise
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 40 == 0) bursting = ($urandom_range(3, 0) == 0);
      cmd = sac_pkg::cmd_t'($urandom_range(3, 0));
      s0 = sac_pkg::LEN_W'($urandom);
      s1 = sac_pkg::LEN_W'($urandom);
      s2 = sac_pkg::LEN_W'($urandom);
      if ($urandom_range(4, 0) != 0) begin
        case (cmd)
          sac_pkg::CMD_CIRCLE: s0 = pick_side();
          sac_pkg::CMD_RECT: begin
            s0 = pick_side();
            s1 = pick_side();
          end
          sac_pkg::CMD_TRI: begin
            // third side mostly strictly between difference and sum of the other two
            s0 = pick_side();
            s1 = pick_side();
            lo = (s0 > s1) ? int'(s0 - s1) + 1 : int'(s1 - s0) + 1;
            hi = int'(s0) + int'(s1) - 1;
            if (hi > int'(LEN_MAX)) hi = int'(LEN_MAX);
            if ($urandom_range(7, 0) == 0) s2 = sac_pkg::LEN_W'(hi + 1);   // not a triangle
            else s2 = sac_pkg::LEN_W'($urandom_range(hi, lo));
            if ($urandom_range(1, 0) != 0) begin
              tmp = s0;
              s0  = s2;
              s2  = tmp;
            end
            if ($urandom_range(1, 0) != 0) begin
              tmp = s1;
              s1  = s2;
              s2  = tmp;
            end
          end
          default: ;
        endcase
      end
      send_item(cmd, s0, s1, s2, 1'b0, '0);
      input_gap(bursting);
    end
    start <= 1'b0;

    // drain the pipeline, then watch for stray results
    while (pending_areas.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
